// File: sv/midirs_pkg.sv
// Types, constants and a helper function shared by the MIDI running status parser.
package midirs_pkg;

    localparam logic       K_FEED         = 1'b0;
    localparam logic       K_CLEAR        = 1'b1;

    localparam logic [7:0] C_REALTIME_MIN = 8'hF8;
    localparam logic [7:0] C_SYSEX_START  = 8'hF0;
    localparam logic [7:0] C_SYSEX_END    = 8'hF7;
    localparam logic [7:0] C_SYSTEM_MIN   = 8'hF0;
    localparam logic [7:0] C_STATUS_MIN   = 8'h80;
    localparam logic [3:0] C_PROG_CHANGE  = 4'hC;
    localparam logic [3:0] C_CHAN_PRESS   = 4'hD;
    localparam logic [7:0] C_TIME_CODE    = 8'hF1;
    localparam logic [7:0] C_SONG_POS     = 8'hF2;
    localparam logic [7:0] C_SONG_SEL     = 8'hF3;

    typedef struct packed {
        logic        kind;
        logic [7:0]  midi_byte;
        logic [63:0] time_stamp;
    } t_in_item;

    typedef struct packed {
        logic [63:0] msg_time;
        logic [7:0]  msg_status;
        logic [6:0]  first_data;
        logic [6:0]  second_data;
    } t_out_item;

    typedef struct packed {
        logic [7:0] running_status;
        logic [7:0] current_status;
        logic [1:0] bytes_expected;
        logic [1:0] bytes_received;
        logic [6:0] data_hold0;
        logic [6:0] data_hold1;
        logic       sysex_active;
    } t_parse_state;

    function automatic logic [1:0] length_of(input logic [7:0] st);
        logic [1:0] len;
        len = 2'd0;
        if (st < C_STATUS_MIN) begin
            len = 2'd0;
        end else if (st < C_SYSTEM_MIN) begin
            len = (st[7:4] == C_PROG_CHANGE || st[7:4] == C_CHAN_PRESS) ? 2'd1 : 2'd2;
        end else if (st == C_TIME_CODE || st == C_SONG_SEL) begin
            len = 2'd1;
        end else if (st == C_SONG_POS) begin
            len = 2'd2;
        end
        return len;
    endfunction

endpackage

// File: sv/midi_running_status_parser_unit.sv
// Top level of the MIDI byte stream parser with running status.
//
// Input channel: i_in_valid / o_in_stall carry one request: a MIDI byte with its
// 64-bit timestamp, or a clear of the parser state. Output channel: o_out_valid /
// i_out_stall carry completed messages (status, up to two data bytes, timestamp
// of the completing byte). A request is taken when valid is high and stall low.
// The result register loads as the completing request leaves the input register,
// which can hold it while a stalled result still occupies the result register.
// Throughput: one request per cycle unless a result waits in a stalled result register,
// set by the single decode step between the input register and the result register.
// Requests that complete no message (real-time bytes, system exclusive, partial
// messages, clears) produce no output and do not wait for the output register.
// When i_out_stall holds a result, the input register still takes one request;
// o_in_stall rises only when that request would produce a result and the result
// register is still occupied.
// Synchronous active-low reset empties both registers and clears running
// status, the message in progress and the system exclusive flag.
module midi_running_status_parser_unit
    import midirs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    logic      w_in_valid;
    t_in_item  w_in_item;
    logic      w_res_valid;
    t_out_item w_res;
    logic      w_out_free;
    logic      w_adv;

    assign w_adv = w_in_valid & (~w_res_valid | w_out_free);

    midirs_input_stage u_input_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_item  (i_in_item),
        .i_adv   (w_adv),
        .o_valid (w_in_valid),
        .o_item  (w_in_item)
    );

    midirs_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (w_in_item),
        .i_commit    (w_adv),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    midirs_output_stage u_output_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_adv & w_res_valid),
        .i_res   (w_res),
        .o_free  (w_out_free),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_item  (o_out_item)
    );

endmodule

// File: sv/midirs_input_stage.sv
// Input register for byte requests.
module midirs_input_stage
    import midirs_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_in_item i_item,
    input  logic     i_adv,
    output logic     o_valid,
    output t_in_item o_item
);

    logic     r_valid;
    logic     n_valid;
    t_in_item r_item;
    logic     w_take;

    assign o_stall = r_valid & ~i_adv;
    assign w_take  = i_valid & ~o_stall;

    always_comb begin
        n_valid = r_valid;
        if (i_adv) begin
            n_valid = 1'b0;
        end
        if (w_take) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// File: sv/midirs_core.sv
// Parser state registers and the per-byte decode logic.
module midirs_core
    import midirs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_item,
    input  logic      i_commit,
    output logic      o_res_valid,
    output t_out_item o_res
);

    t_parse_state r_state;
    t_parse_state n_state;
    logic [7:0]   w_byte;
    logic [7:0]   w_cur;
    logic [1:0]   w_exp;
    logic [1:0]   w_rec;
    logic [1:0]   w_rec_inc;
    logic [6:0]   w_d0;
    logic [6:0]   w_d1;
    logic         w_go;

    assign w_byte = i_item.midi_byte;

    always_comb begin
        n_state              = r_state;
        o_res_valid          = 1'b0;
        o_res                = '0;
        o_res.msg_time       = i_item.time_stamp;
        w_cur                = r_state.current_status;
        w_exp                = r_state.bytes_expected;
        w_rec                = r_state.bytes_received;
        w_go                 = 1'b1;
        w_d0                 = r_state.data_hold0;
        w_d1                 = r_state.data_hold1;
        w_rec_inc            = 2'd0;
        if (i_item.kind == K_CLEAR) begin
            n_state = '0;
        end else if (w_byte >= C_REALTIME_MIN) begin
            n_state = r_state;
        end else if (r_state.sysex_active) begin
            if (w_byte == C_SYSEX_END) begin
                n_state.sysex_active = 1'b0;
            end
        end else if (w_byte[7]) begin
            if (w_byte == C_SYSEX_START) begin
                n_state.sysex_active   = 1'b1;
                n_state.running_status = '0;
                n_state.current_status = '0;
                n_state.bytes_expected = '0;
                n_state.bytes_received = '0;
            end else if (w_byte != C_SYSEX_END) begin
                n_state.current_status = w_byte;
                n_state.bytes_expected = length_of(w_byte);
                n_state.bytes_received = '0;
                n_state.running_status = (w_byte < C_SYSTEM_MIN) ? w_byte : 8'd0;
                if (length_of(w_byte) == 2'd0) begin
                    o_res_valid      = 1'b1;
                    o_res.msg_status = w_byte;
                end
            end
        end else begin
            if (w_exp == 2'd0) begin
                if (r_state.running_status == 8'd0) begin
                    w_go = 1'b0;
                end else begin
                    w_cur = r_state.running_status;
                    w_exp = length_of(r_state.running_status);
                    w_rec = 2'd0;
                end
            end
            if (w_go) begin
                if (w_rec == 2'd0) begin
                    w_d0 = w_byte[6:0];
                end else if (w_rec == 2'd1) begin
                    w_d1 = w_byte[6:0];
                end
                w_rec_inc              = w_rec + 2'd1;
                n_state.current_status = w_cur;
                n_state.bytes_expected = w_exp;
                n_state.data_hold0     = w_d0;
                n_state.data_hold1     = w_d1;
                if (w_rec_inc < w_exp) begin
                    n_state.bytes_received = w_rec_inc;
                end else begin
                    o_res_valid            = 1'b1;
                    o_res.msg_status       = w_cur;
                    o_res.first_data       = w_d0;
                    o_res.second_data      = (w_exp > 2'd1) ? w_d1 : 7'd0;
                    n_state.bytes_received = 2'd0;
                    if (w_cur >= C_SYSTEM_MIN) begin
                        n_state.bytes_expected = 2'd0;
                        n_state.current_status = 8'd0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (i_commit) begin
            r_state <= n_state;
        end
    end

endmodule

// File: sv/midirs_output_stage.sv
// Result register for completed messages.
module midirs_output_stage
    import midirs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_out_item i_res,
    output logic      o_free,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_item
);

    logic      r_valid;
    logic      n_valid;
    t_out_item r_item;

    assign o_free = ~r_valid | ~i_stall;

    always_comb begin
        n_valid = r_valid & i_stall;
        if (i_load) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// File: sim/midi_running_status_parser_checker.sv
// Checker that predicts and compares the messages of the MIDI running status parser.
module midi_running_status_parser_checker
    import midirs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_item  i_in_item,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_item i_out_item,
    output int        o_fail_count,
    output int        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [7:0] run_status;
    logic [7:0] cur_status;
    logic [1:0] data_needed;
    logic [1:0] data_seen;
    logic [6:0] data_bytes [2];
    logic       in_sysex;
    t_out_item  pending_msgs [$];
    t_out_item  want_msg;
    int         mismatch_count = 0;

    assign o_fail_count = mismatch_count;

    function automatic logic [1:0] data_len(input logic [7:0] st);
        if (st < C_STATUS_MIN) begin
            return 2'd0;
        end
        if (st >= C_SYSTEM_MIN) begin
            if (st == C_SONG_POS) begin
                return 2'd2;
            end
            return (st == C_TIME_CODE || st == C_SONG_SEL) ? 2'd1 : 2'd0;
        end
        return (st[7:4] == C_PROG_CHANGE || st[7:4] == C_CHAN_PRESS) ? 2'd1 : 2'd2;
    endfunction

    task automatic clear_parser();
        run_status    = '0;
        cur_status    = '0;
        data_needed   = '0;
        data_seen     = '0;
        data_bytes[0] = '0;
        data_bytes[1] = '0;
        in_sysex      = 1'b0;
    endtask

    task automatic assemble_msg(input t_in_item req);
        logic [7:0] b;
        t_out_item  msg;
        b = req.midi_byte;
        msg.msg_time    = req.time_stamp;
        msg.first_data  = '0;
        msg.second_data = '0;
        if (req.kind == K_CLEAR) begin
            clear_parser();
            return;
        end
        if (b >= C_REALTIME_MIN) begin
            return;
        end
        if (in_sysex) begin
            if (b == C_SYSEX_END) begin
                in_sysex = 1'b0;
            end
            return;
        end
        if (b >= C_STATUS_MIN) begin
            if (b == C_SYSEX_START) begin
                in_sysex    = 1'b1;
                run_status  = '0;
                cur_status  = '0;
                data_needed = '0;
                data_seen   = '0;
                return;
            end
            if (b == C_SYSEX_END) begin
                return;
            end
            cur_status  = b;
            data_needed = data_len(b);
            data_seen   = '0;
            run_status  = (b < C_SYSTEM_MIN) ? b : 8'd0;
            if (data_needed == 2'd0) begin
                msg.msg_status = b;
                pending_msgs.push_back(msg);
            end
            return;
        end
        if (data_needed == 2'd0) begin
            if (run_status == 8'd0) begin
                return;
            end
            cur_status  = run_status;
            data_needed = data_len(run_status);
            data_seen   = '0;
        end
        if (data_seen < 2'd2) begin
            data_bytes[data_seen[0]] = b[6:0];
        end
        data_seen = data_seen + 2'd1;
        if (data_seen < data_needed) begin
            return;
        end
        msg.msg_status  = cur_status;
        msg.first_data  = data_bytes[0];
        msg.second_data = (data_needed > 2'd1) ? data_bytes[1] : 7'd0;
        pending_msgs.push_back(msg);
        data_seen = '0;
        if (cur_status >= C_SYSTEM_MIN) begin
            data_needed = '0;
            cur_status  = '0;
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %h, actual %h", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_parser();
            pending_msgs.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (pending_msgs.size() == 0) begin
                    $error("unexpected message: status %h", i_out_item.msg_status);
                    mismatch_count++;
                end else begin
                    want_msg = pending_msgs.pop_front();
                    check_field("msg_time", want_msg.msg_time, i_out_item.msg_time);
                    check_field("msg_status", 64'(want_msg.msg_status),
                                64'(i_out_item.msg_status));
                    check_field("first_data", 64'(want_msg.first_data),
                                64'(i_out_item.first_data));
                    check_field("second_data", 64'(want_msg.second_data),
                                64'(i_out_item.second_data));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                assemble_msg(i_in_item);
            end
        end
        o_pending = pending_msgs.size();
    end

endmodule

// File: sim/midi_running_status_parser_unit_test.sv
// Testbench top: drives MIDI byte requests into the parser and gives the verdict.
module midi_running_status_parser_unit_test;
    import midirs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BYTE_TARGET = 600;
    localparam int CYCLE_LIMIT = 300000;

    logic      i_clk;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_item   = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_item;
    int        fail_count;
    int        msgs_waiting;
    int        cycle_count = 0;
    int        bytes_fed   = 0;
    int        burst_left  = 0;
    int        stall_left  = 0;
    int        stall_mode  = 0;

    midi_running_status_parser_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    midi_running_status_parser_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_item    (i_in_item),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_item   (o_out_item),
        .o_fail_count (fail_count),
        .o_pending    (msgs_waiting)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = (stall_mode == 3) ? $urandom_range(1, 12) : $urandom_range(5, 40);
        end
        stall_left--;
        case (stall_mode)
            0: begin
                i_out_stall <= 1'b0;
            end
            1: begin
                i_out_stall <= 1'($urandom_range(0, 1));
            end
            2: begin
                i_out_stall <= ($urandom_range(0, 3) != 0);
            end
            default: begin
                i_out_stall <= 1'b1;
            end
        endcase
    end

    task automatic push_req(input logic k, input logic [7:0] b);
        t_in_item req;
        int       gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 20);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        req.kind      = k;
        req.midi_byte = b;
        case ($urandom_range(0, 15))
            0: begin
                req.time_stamp = '0;
            end
            1: begin
                req.time_stamp = '1;
            end
            default: begin
                req.time_stamp = {$urandom, $urandom};
            end
        endcase
        i_in_valid <= 1'b1;
        i_in_item  <= req;
        do @(posedge i_clk); while (o_in_stall);
        if (k == K_CLEAR || b < C_REALTIME_MIN) begin
            bytes_fed++;
        end
        @(negedge i_clk);
    endtask

    // hold the sender until every expected message has come
    task automatic drain_msgs();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (msgs_waiting != 0);
    endtask

    task automatic feed_data();
        if ($urandom_range(0, 9) == 0) begin
            push_req(K_FEED, 8'($urandom_range(C_REALTIME_MIN, 8'hFF)));
        end
        push_req(K_FEED, 8'($urandom_range(0, 127)));
    endtask

    initial begin
        int pick;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        push_req(K_CLEAR, 8'h00);
        push_req(K_FEED, 8'h90); push_req(K_FEED, 8'h3C); push_req(K_FEED, 8'h7F);
        push_req(K_FEED, 8'hC5); push_req(K_FEED, 8'h7F); push_req(K_FEED, 8'h12);
        push_req(K_FEED, C_SYSEX_START); push_req(K_FEED, 8'h90);
        push_req(K_FEED, C_REALTIME_MIN); push_req(K_FEED, C_SYSEX_END);
        push_req(K_FEED, C_SYSEX_END);
        push_req(K_FEED, 8'h45);
        push_req(K_FEED, 8'hF6);
        push_req(K_FEED, C_TIME_CODE); push_req(K_FEED, 8'h23); push_req(K_FEED, 8'h11);
        push_req(K_FEED, C_SONG_POS); push_req(K_FEED, 8'h7F); push_req(K_FEED, 8'h00);
        push_req(K_FEED, 8'hE0); push_req(K_FEED, 8'h10);
        push_req(K_FEED, 8'hA0); push_req(K_FEED, 8'h20); push_req(K_FEED, 8'h30);
        push_req(K_FEED, 8'h90); push_req(K_FEED, 8'h10);
        push_req(K_CLEAR, 8'hFF); push_req(K_FEED, 8'h20);
        drain_msgs();

        while (bytes_fed < BYTE_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 2) begin
                drain_msgs();
            end
            if (pick < 55) begin
                if ($urandom_range(0, 3) != 0) begin
                    push_req(K_FEED, 8'($urandom_range(C_STATUS_MIN, 8'hEF)));
                end
                repeat ($urandom_range(1, 6)) feed_data();
            end else if (pick < 68) begin
                push_req(K_FEED, 8'($urandom_range(C_TIME_CODE, C_SONG_SEL)));
                repeat ($urandom_range(0, 3)) feed_data();
            end else if (pick < 76) begin
                push_req(K_FEED, C_SYSEX_START);
                repeat ($urandom_range(0, 6)) push_req(K_FEED, 8'($urandom_range(0, 255)));
                if ($urandom_range(0, 4) != 0) begin
                    push_req(K_FEED, C_SYSEX_END);
                end
            end else if (pick < 84) begin
                push_req(K_FEED, 8'($urandom_range(8'hF4, C_SYSEX_END)));
            end else if (pick < 88) begin
                push_req(K_CLEAR, 8'($urandom_range(0, 255)));
            end else begin
                push_req(K_FEED, 8'($urandom_range(0, 255)));
            end
        end

        drain_msgs();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
